FILE: design/afu_pkg.sv
// Shared types, mode codes and constant tables for the activation function unit.
// Depends on nothing; every other file of the block imports it.
package afu_pkg;

   localparam int DATA_W    = 16;
   localparam int TAB_DEPTH = 256;
   localparam int TAB_IDX_W = $clog2(TAB_DEPTH);
   localparam int TAB_FR_W  = 19 - TAB_IDX_W;
   localparam int TAB_W     = 21;

   localparam logic [3:0] MODE_IDENTITY = 4'd0;
   localparam logic [3:0] MODE_RELU     = 4'd1;
   localparam logic [3:0] MODE_LEAKY    = 4'd2;
   localparam logic [3:0] MODE_SIGMOID  = 4'd3;
   localparam logic [3:0] MODE_SOFTPLUS = 4'd4;
   localparam logic [3:0] MODE_TANH     = 4'd5;
   localparam logic [3:0] MODE_RELU6    = 4'd6;
   localparam logic [3:0] MODE_HSWISH   = 4'd7;
   localparam logic [3:0] MODE_GELU     = 4'd8;

   localparam logic REG_MODE  = 1'b0;
   localparam logic REG_SLOPE = 1'b1;

   localparam logic [3:0]         MODE_RESET  = MODE_RELU;
   localparam logic signed [15:0] SLOPE_RESET = 16'sd410;

   localparam logic signed [16:0] THREE_Q12 = 17'sd12288;
   localparam logic signed [15:0] SIX_Q12   = 16'sd24576;
   localparam logic [11:0]        GELU_C3   = 12'd2930;
   localparam logic [15:0]        GELU_C1   = 16'd52290;
   localparam logic [15:0]        RECIP3    = 16'd43691;
   localparam logic [21:0]        ONE_Q20   = 22'd1048576;

   localparam logic signed [19:0] SAT_HI = 20'((1 << (DATA_W - 1)) - 1);
   localparam logic signed [19:0] SAT_LO = -SAT_HI - 20'sd1;

   typedef logic [TAB_W-1:0] tab_type [0:TAB_DEPTH];

   typedef struct packed {
      logic                valid;
      logic                last;
      logic [3:0]          mode;
      logic signed [15:0]  x;
      logic                neg;
      logic [15:0]         mag;
      logic signed [19:0]  simple;
      logic [21:0]         targ;
   } front_type;

   typedef struct packed {
      logic                valid;
      logic                last;
      logic [3:0]          mode;
      logic signed [15:0]  x;
      logic                neg;
      logic [15:0]         mag;
      logic signed [19:0]  simple;
      logic [TAB_W-1:0]    tval;
   } lut_out_type;

   typedef struct packed {
      logic                valid;
      logic                last;
      logic [3:0]          mode;
      logic [15:0]         data;
   } result_type;

   // shift-subtract division, only evaluated while building the tables
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], n[i]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // e^-t, t unsigned Q.28, result Q.30
   function automatic logic [63:0] exp_neg_q30(input logic [63:0] t);
      logic [63:0] y;
      logic [63:0] term;
      logic [63:0] v;
      longint      sum;
      y    = t >> 4;
      term = 64'd1 << 30;
      sum  = longint'(64'd1 << 30);
      for (int k = 1; k <= 8; k++) begin
         term = udiv64((term * y) >> 30, 64'(k));
         if (k % 2 == 1) sum = sum - longint'(term);
         else            sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = 64'(sum);
      if (v > (64'd1 << 30)) v = 64'd1 << 30;
      for (int k = 0; k < 6; k++) v = (v * v + (64'd1 << 29)) >> 30;
      return v;
   endfunction

   function automatic tab_type build_tab(input logic want_splus);
      tab_type     tab;
      logic [63:0] e2;
      logic [63:0] e1;
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] p;
      logic [63:0] sum;
      for (int i = 0; i <= TAB_DEPTH; i++) begin
         e2 = exp_neg_q30(udiv64(64'(i) << 32, 64'(TAB_DEPTH)));
         e1 = exp_neg_q30(udiv64(64'(i) << 31, 64'(TAB_DEPTH)));
         if (!want_splus) begin
            tab[i] = TAB_W'(udiv64(((64'd1 << 30) - e2) << 20, (64'd1 << 30) + e2));
         end else begin
            z   = udiv64(e1 << 30, (64'd1 << 31) + e1);
            z2  = (z * z) >> 30;
            p   = z;
            sum = '0;
            for (int n = 0; n <= 10; n++) begin
               sum = sum + udiv64(p, 64'(2 * n + 1));
               p   = (p * z2) >> 30;
            end
            tab[i] = TAB_W'((2 * sum + 64'd512) >> 10);
         end
      end
      return tab;
   endfunction

   localparam tab_type TANH_TAB  = build_tab(1'b0);
   localparam tab_type SPLUS_TAB = build_tab(1'b1);

endpackage

FILE: design/afu_csr.sv
// Configuration registers (mode, leak slope) behind the APB-style port.
// Depends on afu_pkg for register indexes and reset values.
module afu_csr import afu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic [3:0]         mode,
   output logic signed [15:0] slope
);

   logic [3:0]         mode_ff;
   logic signed [15:0] slope_ff;
   logic               wr_en;

   assign wr_en = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_RESET;
         slope_ff <= SLOPE_RESET;
      end else if (wr_en) begin
         case (paddr[2])
            REG_MODE:  mode_ff  <= pwdata[3:0];
            REG_SLOPE: slope_ff <= pwdata[15:0];
            default:   mode_ff  <= mode_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_MODE:  prdata = {28'd0, mode_ff};
         REG_SLOPE: prdata = {16'd0, slope_ff};
         default:   prdata = '0;
      endcase
   end

   assign mode  = mode_ff;
   assign slope = slope_ff;

endmodule

FILE: design/afu_front.sv
// Front pipeline: input capture, magnitude, products for leaky, hard-swish and
// the GELU cubic, simple-mode results and the table argument. Uses afu_pkg.
module afu_front import afu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic               in_last,
   input  logic signed [15:0] in_sample,
   input  logic [3:0]         mode,
   input  logic signed [15:0] slope,
   output front_type          out
);

   // stage A: capture
   logic               va_ff, last_a_ff;
   logic [3:0]         mode_a_ff;
   logic signed [15:0] x_a_ff, slope_a_ff;

   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else if (adv) va_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last_a_ff  <= in_last;
         mode_a_ff  <= mode;
         x_a_ff     <= in_sample;
         slope_a_ff <= slope;
      end
   end

   // stage B: magnitudes and first products
   logic               vb_ff, last_b_ff, neg_b_ff, sn_b_ff;
   logic [3:0]         mode_b_ff;
   logic signed [15:0] x_b_ff;
   logic [15:0]        mag_b_ff, mag_b_in, smag;
   logic [31:0]        sq_b_ff, sq_b_in, lk_b_ff, lk_b_in;
   logic signed [33:0] hs_b_ff, hs_b_in;
   logic signed [16:0] x_plus;

   always_comb begin
      mag_b_in = x_a_ff[15] ? 16'(-x_a_ff) : 16'(x_a_ff);
      smag     = slope_a_ff[15] ? 16'(-slope_a_ff) : 16'(slope_a_ff);
      sq_b_in  = 32'(mag_b_in) * 32'(mag_b_in);
      lk_b_in  = 32'(mag_b_in) * 32'(smag);
      x_plus   = 17'(x_a_ff) + THREE_Q12;
      hs_b_in  = 34'(x_a_ff) * 34'(x_plus);
   end

   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else if (adv) vb_ff <= va_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last_b_ff <= last_a_ff;
         mode_b_ff <= mode_a_ff;
         x_b_ff    <= x_a_ff;
         neg_b_ff  <= x_a_ff[15];
         sn_b_ff   <= slope_a_ff[15];
         mag_b_ff  <= mag_b_in;
         sq_b_ff   <= sq_b_in;
         lk_b_ff   <= lk_b_in;
         hs_b_ff   <= hs_b_in;
      end
   end

   // stage C: cube, leaky rounding, simple results
   logic               vc_ff, last_c_ff, neg_c_ff, hsneg_c_ff, hsmid_c_ff, hsmid_c_in;
   logic [3:0]         mode_c_ff;
   logic signed [15:0] x_c_ff;
   logic [15:0]        mag_c_ff, n_c_ff, n_c_in;
   logic [47:0]        cube_c_ff, cube_c_in;
   logic signed [19:0] simple_c_ff, simple_c_in, lk_res;
   logic [32:0]        lk_round;
   logic [19:0]        lk_mag;
   logic [33:0]        habs, hround;

   always_comb begin
      cube_c_in  = 48'(sq_b_ff) * 48'(mag_b_ff);
      lk_round   = 33'(lk_b_ff) + 33'd2048;
      lk_mag     = lk_round[31:12];
      lk_res     = (sn_b_ff != neg_b_ff) ? -$signed(lk_mag) : $signed(lk_mag);
      habs       = hs_b_ff[33] ? 34'(-hs_b_ff) : 34'(hs_b_ff);
      hround     = habs + 34'd12288;
      n_c_in     = hround[28:13];
      hsmid_c_in = 1'b0;
      case (mode_b_ff)
         MODE_RELU:   simple_c_in = neg_b_ff ? 20'sd0 : 20'(x_b_ff);
         MODE_LEAKY:  simple_c_in = (x_b_ff > 16'sd0) ? 20'(x_b_ff) : lk_res;
         MODE_RELU6: begin
            if (neg_b_ff)              simple_c_in = 20'sd0;
            else if (x_b_ff > SIX_Q12) simple_c_in = 20'(SIX_Q12);
            else                       simple_c_in = 20'(x_b_ff);
         end
         MODE_HSWISH: begin
            if (17'(x_b_ff) < -THREE_Q12)    simple_c_in = 20'sd0;
            else if (17'(x_b_ff) > THREE_Q12) simple_c_in = 20'(x_b_ff);
            else begin
               simple_c_in = 20'sd0;
               hsmid_c_in  = 1'b1;
            end
         end
         default:     simple_c_in = 20'(x_b_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else if (adv) vc_ff <= vb_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last_c_ff   <= last_b_ff;
         mode_c_ff   <= mode_b_ff;
         x_c_ff      <= x_b_ff;
         neg_c_ff    <= neg_b_ff;
         mag_c_ff    <= mag_b_ff;
         cube_c_ff   <= cube_c_in;
         simple_c_ff <= simple_c_in;
         n_c_ff      <= n_c_in;
         hsneg_c_ff  <= hs_b_ff[33];
         hsmid_c_ff  <= hsmid_c_in;
      end
   end

   // stage D: GELU cubic term, hard-swish divide by three
   logic               vd_ff, last_d_ff, neg_d_ff;
   logic [3:0]         mode_d_ff;
   logic signed [15:0] x_d_ff;
   logic [15:0]        mag_d_ff;
   logic [59:0]        prod3_d_ff, prod3_d_in;
   logic signed [19:0] simple_d_ff, simple_d_in;
   logic [31:0]        hq_prod;
   logic [19:0]        hq;

   always_comb begin
      prod3_d_in  = 60'(cube_c_ff) * 60'(GELU_C3);
      hq_prod     = 32'(n_c_ff) * 32'(RECIP3);
      hq          = 20'(hq_prod[31:17]);
      simple_d_in = simple_c_ff;
      if (hsmid_c_ff) simple_d_in = hsneg_c_ff ? -$signed(hq) : $signed(hq);
   end

   always_ff @(posedge clock) begin
      if (reset) vd_ff <= 1'b0;
      else if (adv) vd_ff <= vc_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last_d_ff   <= last_c_ff;
         mode_d_ff   <= mode_c_ff;
         x_d_ff      <= x_c_ff;
         neg_d_ff    <= neg_c_ff;
         mag_d_ff    <= mag_c_ff;
         prod3_d_ff  <= prod3_d_in;
         simple_d_ff <= simple_d_in;
      end
   end

   // stage E: GELU inner argument and table argument
   front_type   out_ff, out_in;
   logic [19:0] gv;
   logic [35:0] gu;

   always_comb begin
      gv = 20'(mag_d_ff) + prod3_d_ff[59:40];
      gu = 36'(gv) * 36'(GELU_C1);
      out_in.valid  = vd_ff;
      out_in.last   = last_d_ff;
      out_in.mode   = mode_d_ff;
      out_in.x      = x_d_ff;
      out_in.neg    = neg_d_ff;
      out_in.mag    = mag_d_ff;
      out_in.simple = simple_d_ff;
      case (mode_d_ff)
         MODE_SIGMOID:  out_in.targ = 22'(mag_d_ff) << 3;
         MODE_SOFTPLUS,
         MODE_TANH:     out_in.targ = 22'(mag_d_ff) << 4;
         MODE_GELU:     out_in.targ = gu[33:12];
         default:       out_in.targ = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) out_ff.valid <= 1'b0;
      else if (adv) out_ff <= out_in;
   end

   assign out = out_ff;

endmodule

FILE: design/afu_lut.sv
// Table read and linear interpolation over the tanh and softplus tables.
// Two register stages; uses afu_pkg for the tables and stage types.
module afu_lut import afu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  front_type   fin,
   output lut_out_type out
);

   // stage L1: read both neighbouring points
   lut_out_type            l1_ff, l1_in;
   logic                   up_ff, up_in;
   logic [TAB_W-1:0]       lo_ff, lo_in, hi_pt, dmag_ff, dmag_in;
   logic [TAB_FR_W-1:0]    fr_ff, fr_in;
   logic [TAB_IDX_W:0]     idx, idx_nx;
   logic                   use_splus;

   always_comb begin
      use_splus = (fin.mode == MODE_SOFTPLUS);
      idx       = {1'b0, fin.targ[18 -: TAB_IDX_W]};
      idx_nx    = idx + 1'b1;
      fr_in     = fin.targ[TAB_FR_W-1:0];
      if (fin.targ[21:19] != 3'd0) begin
         idx    = (TAB_IDX_W + 1)'(TAB_DEPTH);
         idx_nx = (TAB_IDX_W + 1)'(TAB_DEPTH);
      end
      lo_in   = use_splus ? SPLUS_TAB[idx]    : TANH_TAB[idx];
      hi_pt   = use_splus ? SPLUS_TAB[idx_nx] : TANH_TAB[idx_nx];
      up_in   = (hi_pt >= lo_in);
      dmag_in = up_in ? hi_pt - lo_in : lo_in - hi_pt;
      l1_in.valid  = fin.valid;
      l1_in.last   = fin.last;
      l1_in.mode   = fin.mode;
      l1_in.x      = fin.x;
      l1_in.neg    = fin.neg;
      l1_in.mag    = fin.mag;
      l1_in.simple = fin.simple;
      l1_in.tval   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) l1_ff.valid <= 1'b0;
      else if (adv) l1_ff <= l1_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lo_ff   <= lo_in;
         up_ff   <= up_in;
         dmag_ff <= dmag_in;
         fr_ff   <= fr_in;
      end
   end

   // stage L2: interpolate, truncating toward the lower point
   lut_out_type                 l2_ff, l2_in;
   logic [TAB_W+TAB_FR_W-1:0]   step_prod;
   logic [TAB_W-1:0]            step;

   always_comb begin
      step_prod = (TAB_W + TAB_FR_W)'(dmag_ff) * (TAB_W + TAB_FR_W)'(fr_ff);
      step      = step_prod[TAB_W+TAB_FR_W-1:TAB_FR_W];
      l2_in      = l1_ff;
      l2_in.tval = up_ff ? lo_ff + step : lo_ff - step;
   end

   always_ff @(posedge clock) begin
      if (reset) l2_ff.valid <= 1'b0;
      else if (adv) l2_ff <= l2_in;
   end

   assign out = l2_ff;

endmodule

FILE: design/afu_back.sv
// Back pipeline: table-based mode results, GELU product, saturation and the
// output register. Uses afu_pkg for mode codes and stage types.
module afu_back import afu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  lut_out_type lin,
   output result_type  out
);

   // stage P1
   logic               v1_ff, last1_ff, neg1_ff;
   logic [3:0]         mode1_ff;
   logic signed [19:0] res1_ff, res1_in;
   logic [37:0]        gprod_ff, gprod_in;
   logic [21:0]        q, sig_sum;
   logic [21:0]        g_sum;
   logic [19:0]        sig, g;

   always_comb begin
      q       = lin.neg ? ONE_Q20 - 22'(lin.tval) : ONE_Q20 + 22'(lin.tval);
      sig_sum = q + 22'd256;
      sig     = 20'(sig_sum[21:9]);
      g_sum   = 22'(lin.tval) + 22'd128;
      g       = 20'(g_sum[21:8]);
      gprod_in = 38'(lin.mag) * 38'(q);
      case (lin.mode)
         MODE_SIGMOID:  res1_in = $signed(sig);
         MODE_SOFTPLUS: res1_in = (lin.neg ? 20'sd0 : 20'(lin.x)) + $signed(g);
         MODE_TANH:     res1_in = lin.neg ? -$signed(g) : $signed(g);
         default:       res1_in = lin.simple;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= lin.valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last1_ff <= lin.last;
         neg1_ff  <= lin.neg;
         mode1_ff <= lin.mode;
         res1_ff  <= res1_in;
         gprod_ff <= gprod_in;
      end
   end

   // stage P2: GELU rounding, saturate, output register
   result_type         out_ff, out_in;
   logic [37:0]        gsum;
   logic [19:0]        gmag;
   logic signed [19:0] fin;

   always_comb begin
      gsum = gprod_ff + 38'(ONE_Q20);
      gmag = 20'(gsum[37:21]);
      fin  = res1_ff;
      if (mode1_ff == MODE_GELU) fin = neg1_ff ? -$signed(gmag) : $signed(gmag);
      out_in.valid = v1_ff;
      out_in.last  = last1_ff;
      out_in.mode  = mode1_ff;
      if (fin > SAT_HI)      out_in.data = 16'(SAT_HI);
      else if (fin < SAT_LO) out_in.data = 16'(SAT_LO);
      else                   out_in.data = 16'(fin);
   end

   always_ff @(posedge clock) begin
      if (reset) out_ff.valid <= 1'b0;
      else if (adv) out_ff <= out_in;
   end

   assign out = out_ff;

endmodule

FILE: design/activation_function_unit.sv
// Activation function unit: nine-stage pipeline, one transaction per cycle while the output is not stalled.
// An accepted sample moves through stages A to E, L1, L2, P1 and P2 onto rsp_.
// Throughput: one sample per cycle, set by the fully pipelined datapath; a
// stalled output holds every stage in place.
// Reset: synchronous, clears all stage valid bits; mode resets to ReLU and
// leak slope to 410 (about 0.1). Tables are constants, no fill after reset.
module activation_function_unit import afu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] result
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic               adv;
   logic [3:0]         mode;
   logic signed [15:0] slope;
   front_type          front_out;
   lut_out_type        lut_out;
   result_type         res;

   // advance the whole pipe unless the output transaction is stalled
   assign adv        = !res.valid || rsp_tready;
   assign req_tready = adv;
   assign csr_pready = 1'b1;

   afu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .mode    (mode),
      .slope   (slope)
   );

   afu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid),
      .in_last   (req_tlast),
      .in_sample (req_tdata),
      .mode      (mode),
      .slope     (slope),
      .out       (front_out)
   );

   afu_lut u_lut (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .fin   (front_out),
      .out   (lut_out)
   );

   afu_back u_back (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .lin   (lut_out),
      .out   (res)
   );

   assign rsp_tvalid = res.valid;
   assign rsp_tdata  = res.data;
   assign rsp_tlast  = res.last;

   a_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (res.mode == MODE_RELU || res.mode == MODE_RELU6 ||
                     res.mode == MODE_SIGMOID) |-> !rsp_tdata[15])
      else $error("negative result in a non-negative mode");

   a_relu6_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res.mode == MODE_RELU6 |-> rsp_tdata <= 16'(SIX_Q12))
      else $error("relu6 result above six");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(front_out) && $stable(lut_out))
      else $error("pipeline moved during output stall");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for activation_function_unit: streams Q4.12 samples
// through every mode and compares each result with a local model of the unit.
// Depends on afu_pkg (mode codes, widths) and the RTL of the block.
`timescale 1ns / 1ps

module tb;
   import afu_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_RANDOM       = 1100;
   localparam int TAB_N          = 256;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   activation_function_unit dut (.*);

   always #2 clock = ~clock;

   typedef struct {
      logic [15:0] result;
      logic        last;
   } act_out_type;

   typedef struct {
      logic [15:0] sample;
      logic        last;
      logic        typed;
      logic [15:0] result;
   } stim_row_type;

   act_out_type pending_results[$];
   logic [31:0] tanh_lut[0:TAB_N];
   logic [31:0] splus_lut[0:TAB_N];
   logic [3:0]  cur_mode = MODE_RESET;
   logic [15:0] cur_slope = SLOPE_RESET;
   int errors = 0, mismatches = 0, n_sent = 0, n_checked = 0, idle_cycles = 0;
   bit timed_out = 1'b0, no_idle = 1'b0, hold_rsp = 1'b0;
   int hold_len = 0;
   int rsp_gap = 0;

   // e^-t, t unsigned Q.28, result Q.30
   function automatic longint unsigned exp_neg(longint unsigned t);
      longint unsigned y, term, v;
      longint sum;
      y = t >> 4;
      term = 64'd1 << 30;
      sum = longint'(64'd1 << 30);
      for (int k = 1; k <= 8; k++) begin
         term = ((term * y) >> 30) / longint'(k);
         if (k % 2 == 1) sum -= longint'(term);
         else            sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      v = sum;
      if (v > (64'd1 << 30)) v = 64'd1 << 30;
      for (int k = 0; k < 6; k++) v = (v * v + (64'd1 << 29)) >> 30;
      return v;
   endfunction

   task automatic fill_luts();
      longint unsigned e1, e2, z, z2, p, sum, ii;
      for (int i = 0; i <= TAB_N; i++) begin
         ii = i;
         e2 = exp_neg((ii << 32) / TAB_N);
         e1 = exp_neg((ii << 31) / TAB_N);
         tanh_lut[i] = 32'((((64'd1 << 30) - e2) << 20) / ((64'd1 << 30) + e2));
         z = (e1 << 30) / ((64'd1 << 31) + e1);
         z2 = (z * z) >> 30;
         p = z;
         sum = 0;
         for (int n = 0; n <= 10; n++) begin
            sum += p / longint'(2 * n + 1);
            p = (p * z2) >> 30;
         end
         splus_lut[i] = 32'((2 * sum + 512) >> 10);
      end
   endtask

   function automatic longint unsigned lut_read(bit splus, longint unsigned t);
      longint unsigned p, idx, f, a, b;
      if (t >= (64'd1 << 19)) return splus ? splus_lut[TAB_N] : tanh_lut[TAB_N];
      p = t * TAB_N;
      idx = p >> 19;
      f = p & ((64'd1 << 19) - 1);
      a = splus ? splus_lut[idx] : tanh_lut[idx];
      b = splus ? splus_lut[idx + 1] : tanh_lut[idx + 1];
      if (b >= a) return a + (((b - a) * f) >> 19);
      return a - (((a - b) * f) >> 19);
   endfunction

   function automatic logic [15:0] activate(logic [15:0] sample);
      longint x, s, r, pr;
      longint unsigned a, mag, t, q, v, u;
      bit neg, sn;
      x = longint'($signed(sample));
      neg = x < 0;
      a = neg ? -x : x;
      case (cur_mode)
         MODE_RELU: r = neg ? 0 : x;
         MODE_LEAKY: begin
            s = longint'($signed(cur_slope));
            if (x > 0) r = x;
            else begin
               sn = s < 0;
               mag = (a * longint'(sn ? -s : s) + 2048) >> 12;
               r = (sn != neg) ? -longint'(mag) : longint'(mag);
            end
         end
         MODE_SIGMOID: begin
            t = lut_read(1'b0, a << 3);
            q = neg ? (64'd1 << 20) - t : (64'd1 << 20) + t;
            r = (q + 256) >> 9;
         end
         MODE_SOFTPLUS: r = (neg ? 0 : x) + longint'((lut_read(1'b1, a << 4) + 128) >> 8);
         MODE_TANH: begin
            mag = (lut_read(1'b0, a << 4) + 128) >> 8;
            r = neg ? -longint'(mag) : longint'(mag);
         end
         MODE_RELU6: r = neg ? 0 : (x > 24576 ? 24576 : x);
         MODE_HSWISH: begin
            if (x < -12288) r = 0;
            else if (x > 12288) r = x;
            else begin
               pr = x * (x + 12288);
               mag = (longint'(pr < 0 ? -pr : pr) + 12288) / 24576;
               r = pr < 0 ? -longint'(mag) : longint'(mag);
            end
         end
         MODE_GELU: begin
            v = a + ((2930 * a * a * a) >> 40);
            u = (52290 * v) >> 12;
            t = lut_read(1'b0, u);
            q = neg ? (64'd1 << 20) - t : (64'd1 << 20) + t;
            mag = (a * q + (64'd1 << 20)) >> 21;
            r = neg ? -longint'(mag) : longint'(mag);
         end
         default: r = x;
      endcase
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (addr == 3'(4 * REG_MODE)) cur_mode = data[3:0];
      else cur_slope = data[15:0];
   endtask

   task automatic drain();
      while (pending_results.size() != 0 && !timed_out) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic send_sample(logic [15:0] sample, logic last, bit typed, logic [15:0] want);
      act_out_type e;
      if (!no_idle && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_tvalid <= 1'b1; req_tdata <= sample; req_tlast <= last;
      e.result = activate(sample);
      if (typed && e.result != want) begin
         errors++;
         $display("model disagrees with table row: sample %h want %h got %h",
                  sample, want, e.result);
      end
      e.last = last;
      pending_results.push_back(e);
      do @(posedge clock); while (!req_tready);
      n_sent++;
      @(negedge clock);
   endtask

   task automatic finish_stream();
      req_tvalid <= 1'b0;
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 65535));
         1: return 16'($signed($urandom_range(0, 32767)) - 16384);
         2: return 16'($urandom_range(0, 4095)) ^ {16{$urandom_range(0, 1) == 1}};
         3: return $urandom_range(0, 1) ? 16'h7FFF - 16'($urandom_range(0, 15))
                                      : 16'h8000 + 16'($urandom_range(0, 15));
         default: return 16'($signed($urandom_range(0, 24576)) - 12288);
      endcase
   endfunction

   // receiver: random stall bursts, one long hold-off on request
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_rsp) begin
         rsp_tready <= 1'b0;
         if (hold_len > 0) hold_len--;
         else hold_rsp <= 1'b0;
      end else if (no_idle) rsp_tready <= 1'b1;
      else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap--;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         rsp_gap = $urandom_range(0, 15);
      end else rsp_tready <= 1'b1;
   end

   // result checker
   always @(posedge clock) begin
      act_out_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_checked++;
         if (pending_results.size() == 0) begin
            errors++;
            $display("unexpected result %h last %b", rsp_tdata, rsp_tlast);
         end else begin
            e = pending_results.pop_front();
            if (e.result !== rsp_tdata || e.last !== rsp_tlast) begin
               errors++;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: mode %0d expected %h/%b actual %h/%b",
                           cur_mode, e.result, e.last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         timed_out = 1'b1;
         $display("RESULT: ERROR");
         $finish;
      end
   end

   stim_row_type dir_rows[] = '{
      '{16'h0000, 1'b0, 1'b1, 16'h0000},
      '{16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
      '{16'h8000, 1'b1, 1'b1, 16'h0000},
      '{16'hFFFF, 1'b0, 1'b1, 16'h0000},
      '{16'h0001, 1'b1, 1'b1, 16'h0001},
      '{16'h1000, 1'b0, 1'b0, 16'h0000},
      '{16'hF000, 1'b0, 1'b0, 16'h0000},
      '{16'h3000, 1'b0, 1'b0, 16'h0000},
      '{16'hD000, 1'b0, 1'b0, 16'h0000},
      '{16'h6000, 1'b0, 1'b0, 16'h0000},
      '{16'h6001, 1'b0, 1'b0, 16'h0000},
      '{16'h2FFF, 1'b0, 1'b0, 16'h0000},
      '{16'hD001, 1'b1, 1'b0, 16'h0000}
   };
   logic [3:0] mode_list[] = '{MODE_IDENTITY, MODE_RELU, MODE_LEAKY, MODE_SIGMOID,
      MODE_SOFTPLUS, MODE_TANH, MODE_RELU6, MODE_HSWISH, MODE_GELU, 4'd9, 4'd15};
   logic [15:0] slope_list[] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h1000};

   initial begin
      fill_luts();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: ReLU
      foreach (dir_rows[i])
         send_sample(dir_rows[i].sample, dir_rows[i].last, dir_rows[i].typed,
                     dir_rows[i].result);
      finish_stream();
      drain();

      // every mode over the directed rows; leaky over the later rows for each slope
      foreach (mode_list[m]) begin
         csr_write(3'(4 * REG_MODE), 32'(mode_list[m]));
         if (mode_list[m] == MODE_LEAKY) begin
            foreach (slope_list[s]) begin
               csr_write(3'(4 * REG_SLOPE), 32'(slope_list[s]));
               for (int i = 5; i < dir_rows.size(); i++)
                  send_sample(dir_rows[i].sample, dir_rows[i].last, 1'b0, '0);
               send_sample(16'h8000, 1'b0, 1'b0, '0);
               finish_stream();
               drain();
            end
         end else begin
            for (int i = 0; i < dir_rows.size(); i++)
               send_sample(dir_rows[i].sample, dir_rows[i].last, 1'b0, '0);
            finish_stream();
            drain();
         end
      end

      // random phases, one mode each; long receiver hold-off in the first
      for (int ph = 0; ph < 13; ph++) begin
         csr_write(3'(4 * REG_MODE), 32'(ph < 11 ? mode_list[ph] : $urandom_range(0, 15)));
         csr_write(3'(4 * REG_SLOPE), $urandom_range(0, 65535));
         if (ph == 0) begin
            hold_len = 300;
            hold_rsp = 1'b1;
         end
         no_idle = (ph == 12);
         for (int i = 0; i < N_RANDOM / 13; i++)
            send_sample(rand_sample(), 1'($urandom_range(0, 1)), 1'b0, '0);
         finish_stream();
         drain();
      end

      $display("sent %0d samples over all modes and slope extremes, %0d results checked",
               n_sent, n_checked);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d failures, %0d mismatches", errors, mismatches);
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
